[rtl/sacl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and constants for the set-associative cache with lookahead
// prefetch.
// ----------------------------------------------------------------------------
package sacl_pkg;

    localparam int AGE_W = 16;
    localparam logic [AGE_W-1:0] AGE_MAX = 16'hFFFF;
    localparam logic [15:0] LFSR_MASK = 16'hB400;
    localparam logic [15:0] LFSR_SEED = 16'h0001;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_THROUGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USE_LRU = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXPIRY_LIMIT = 2'd2;
    localparam logic [AGE_W-1:0] EXPIRY_RESET = 16'd1024;

    typedef enum logic [5:0] {
        ST_CLR  = 6'b000001,
        ST_IDLE = 6'b000010,
        ST_REM  = 6'b000100,
        ST_RD   = 6'b001000,
        ST_MOD  = 6'b010000,
        ST_FIN  = 6'b100000
    } t_state;

    typedef enum logic [1:0] {
        OP_SWEEP = 2'd0,
        OP_LOOK  = 2'd1,
        OP_PF1   = 2'd2,
        OP_PF2   = 2'd3
    } t_op;

endpackage

[rtl/set_assoc_cache_lookahead_prefetch.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_lookahead_prefetch
// Tag store with per-way ages, expiry, LRU or random fill and next-address
// prefetch, held in one row-per-set memory.
// ----------------------------------------------------------------------------
// Each set is one memory row, and every row access is a read and then a
// modified write back. An allocating access (load, or any access in
// write-through mode) first ages every set, then reads and writes its own
// set and, when lookahead is valid, each lookahead set; with LRU off the
// random way choice is worked out before the aging pass. A write-back store
// touches only its own set. One more state loads the result register, and
// an input word is taken only while no access is in progress. After reset
// a clearing pass writes every row before the first input word is taken.
module set_assoc_cache_lookahead_prefetch #(
    parameter int OFFSET_BITS = 6,
    parameter int SET_BITS = 6,
    parameter int WAYS = 4,
    parameter int ADDRESS_BITS = 48
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic [sacl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // address, next_address_first, next_address_second
    input  logic [((3*ADDRESS_BITS+7)/8)*8-1:0] i_s_tdata,
    // is_load, lookahead_valid
    input  logic [1:0] i_s_tuser,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // hit, prefetch_count[1:0], zero fill
    output logic [7:0] o_m_tdata
);

    localparam int AW = sacl_pkg::AGE_W;
    localparam int TAG_W = ADDRESS_BITS - OFFSET_BITS - SET_BITS;
    localparam int ENT_W = 1 + TAG_W + AW;
    localparam int ROW_W = WAYS * ENT_W;
    localparam int NUM_SETS = 1 << SET_BITS;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam logic [20:0] WAYS_V = 21'(WAYS);
    localparam logic [21:0] RECIP = 22'(((1 << 21) + WAYS - 1) / WAYS);

    logic [ROW_W-1:0] mem [NUM_SETS];
    logic [ROW_W-1:0] r_rdata;
    logic [ROW_W-1:0] n_row;

    sacl_pkg::t_state r_state, n_state;
    sacl_pkg::t_op r_op;
    logic [SET_BITS-1:0] r_idx;
    logic [SET_BITS-1:0] raddr;
    logic r_wt, r_lru;
    logic [AW-1:0] r_expiry;
    logic [15:0] r_lfsr;
    logic [15:0] r_rem;
    logic [15:0] r_quo;
    logic [3:0] r_step;
    logic r_alloc, r_look, r_rand;
    logic [ADDRESS_BITS-1:0] r_addr, r_na1, r_na2;
    logic r_hit;
    logic [1:0] r_cnt;
    logic r_out_valid;
    logic [2:0] r_out;

    logic s_acc;
    logic [ADDRESS_BITS-1:0] cur_addr;
    logic [TAG_W-1:0] cur_tag;
    logic look_hit, pf_done;
    logic [15:0] lfsr_next;
    logic [36:0] rem_prod;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready = (r_state == sacl_pkg::ST_IDLE);
    assign s_acc = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata = {5'd0, r_out};
    assign lfsr_next = r_lfsr[0] ? ((r_lfsr >> 1) ^ sacl_pkg::LFSR_MASK) : (r_lfsr >> 1);
    assign rem_prod = {21'd0, r_rem} * {15'd0, RECIP};

    always_comb begin
        case (r_op)
            sacl_pkg::OP_PF1: cur_addr = r_na1;
            sacl_pkg::OP_PF2: cur_addr = r_na2;
            default:          cur_addr = r_addr;
        endcase
        cur_tag = cur_addr[OFFSET_BITS+SET_BITS +: TAG_W];
        if (r_op == sacl_pkg::OP_SWEEP || r_state == sacl_pkg::ST_CLR) begin
            raddr = r_idx;
        end else begin
            raddr = cur_addr[OFFSET_BITS +: SET_BITS];
        end
    end

    always_comb begin
        logic [WAYS-1:0] v, hv;
        logic [TAG_W-1:0] tg [WAYS];
        logic [AW-1:0] ag [WAYS];
        logic [AW-1:0] a, mx;
        logic [WAY_W-1:0] k, vic, pos;
        logic found, present;
        for (int w = 0; w < WAYS; w++) begin
            v[w] = r_rdata[w*ENT_W];
            tg[w] = r_rdata[w*ENT_W+1 +: TAG_W];
            ag[w] = r_rdata[w*ENT_W+1+TAG_W +: AW];
        end
        hv = '0;
        k = '0;
        vic = '0;
        pos = '0;
        found = 1'b0;
        present = 1'b0;
        a = '0;
        mx = '0;
        look_hit = 1'b0;
        pf_done = 1'b0;
        case (r_op)
            sacl_pkg::OP_SWEEP: begin
                for (int w = 0; w < WAYS; w++) begin
                    a = (ag[w] == sacl_pkg::AGE_MAX) ? ag[w] : ag[w] + 1'b1;
                    if (a >= r_expiry) begin
                        v[w] = 1'b0;
                        tg[w] = '0;
                        a = '0;
                    end
                    ag[w] = a;
                end
            end
            sacl_pkg::OP_LOOK: begin
                for (int w = 0; w < WAYS; w++) begin
                    if (!r_alloc && ag[w] != sacl_pkg::AGE_MAX) begin
                        ag[w] = ag[w] + 1'b1;
                    end
                    hv[w] = v[w] && (tg[w] == r_addr[OFFSET_BITS+SET_BITS +: TAG_W]);
                    if (hv[w]) begin
                        ag[w] = '0;
                    end
                end
                for (int w = 0; w < WAYS; w++) begin
                    if (!hv[w] && ag[w] > ag[k]) begin
                        k = WAY_W'(w);
                    end
                end
                look_hit = |hv;
                vic = r_rand ? r_rem[WAY_W-1:0] : k;
                if (r_alloc && !look_hit) begin
                    for (int w = 0; w < WAYS; w++) begin
                        if (vic == WAY_W'(w)) begin
                            v[w] = 1'b1;
                            tg[w] = r_addr[OFFSET_BITS+SET_BITS +: TAG_W];
                            ag[w] = '0;
                        end
                    end
                end
            end
            default: begin
                for (int w = 0; w < WAYS; w++) begin
                    if (!v[w] && !found) begin
                        found = 1'b1;
                        pos = WAY_W'(w);
                    end
                    if (ag[w] > mx) begin
                        mx = ag[w];
                    end
                    if (v[w] && tg[w] == cur_tag) begin
                        present = 1'b1;
                    end
                end
                pf_done = found && !present;
                if (pf_done) begin
                    for (int w = 0; w < WAYS; w++) begin
                        if (pos == WAY_W'(w)) begin
                            v[w] = 1'b1;
                            tg[w] = cur_tag;
                            ag[w] = (mx == sacl_pkg::AGE_MAX) ? mx : mx + 1'b1;
                        end
                    end
                end
            end
        endcase
        for (int w = 0; w < WAYS; w++) begin
            n_row[w*ENT_W] = v[w];
            n_row[w*ENT_W+1 +: TAG_W] = tg[w];
            n_row[w*ENT_W+1+TAG_W +: AW] = ag[w];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == sacl_pkg::ST_RD) begin
            r_rdata <= mem[raddr];
        end
        if (r_state == sacl_pkg::ST_CLR) begin
            mem[raddr] <= '0;
        end else if (r_state == sacl_pkg::ST_MOD) begin
            mem[raddr] <= n_row;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sacl_pkg::ST_CLR: begin
                if (&r_idx) begin
                    n_state = sacl_pkg::ST_IDLE;
                end
            end
            sacl_pkg::ST_IDLE: begin
                if (s_acc) begin
                    if ((r_wt || i_s_tuser[0]) && !r_lru) begin
                        n_state = sacl_pkg::ST_REM;
                    end else begin
                        n_state = sacl_pkg::ST_RD;
                    end
                end
            end
            sacl_pkg::ST_REM: begin
                if (r_step == 4'd0) begin
                    n_state = sacl_pkg::ST_RD;
                end
            end
            sacl_pkg::ST_RD: n_state = sacl_pkg::ST_MOD;
            sacl_pkg::ST_MOD: begin
                if ((r_op == sacl_pkg::OP_LOOK && !(r_alloc && r_look))
                        || r_op == sacl_pkg::OP_PF2) begin
                    n_state = sacl_pkg::ST_FIN;
                end else begin
                    n_state = sacl_pkg::ST_RD;
                end
            end
            sacl_pkg::ST_FIN: begin
                if (!r_out_valid || i_m_tready) begin
                    n_state = sacl_pkg::ST_IDLE;
                end
            end
            default: n_state = sacl_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sacl_pkg::ST_CLR;
            r_idx <= '0;
            r_op <= sacl_pkg::OP_SWEEP;
            r_wt <= 1'b0;
            r_lru <= 1'b1;
            r_expiry <= sacl_pkg::EXPIRY_RESET;
            r_lfsr <= sacl_pkg::LFSR_SEED;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    sacl_pkg::REG_WRITE_THROUGH: r_wt <= i_cfg_data[0];
                    sacl_pkg::REG_USE_LRU:       r_lru <= i_cfg_data[0];
                    sacl_pkg::REG_EXPIRY_LIMIT:  r_expiry <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == sacl_pkg::ST_FIN && (!r_out_valid || i_m_tready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                sacl_pkg::ST_CLR: r_idx <= r_idx + 1'b1;
                sacl_pkg::ST_IDLE: begin
                    if (s_acc) begin
                        r_idx <= '0;
                        r_op <= (r_wt || i_s_tuser[0]) ? sacl_pkg::OP_SWEEP
                                                       : sacl_pkg::OP_LOOK;
                        if ((r_wt || i_s_tuser[0]) && !r_lru) begin
                            r_lfsr <= lfsr_next;
                        end
                    end
                end
                sacl_pkg::ST_MOD: begin
                    if (r_op == sacl_pkg::OP_SWEEP) begin
                        r_idx <= r_idx + 1'b1;
                        if (&r_idx) begin
                            r_op <= sacl_pkg::OP_LOOK;
                        end
                    end else if (r_op == sacl_pkg::OP_LOOK) begin
                        r_op <= sacl_pkg::OP_PF1;
                    end else if (r_op == sacl_pkg::OP_PF1) begin
                        r_op <= sacl_pkg::OP_PF2;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_addr <= i_s_tdata[ADDRESS_BITS-1:0];
            r_na1 <= i_s_tdata[ADDRESS_BITS +: ADDRESS_BITS];
            r_na2 <= i_s_tdata[2*ADDRESS_BITS +: ADDRESS_BITS];
            r_alloc <= r_wt || i_s_tuser[0];
            r_look <= i_s_tuser[1];
            r_rand <= (r_wt || i_s_tuser[0]) && !r_lru;
            r_rem <= lfsr_next;
            r_step <= 4'd1;
            r_cnt <= 2'd0;
        end
        if (r_state == sacl_pkg::ST_REM) begin
            if (r_step == 4'd1) begin
                r_quo <= rem_prod[36:21];
            end else begin
                r_rem <= r_rem - 16'({5'd0, r_quo} * WAYS_V);
            end
            r_step <= r_step - 1'b1;
        end
        if (r_state == sacl_pkg::ST_MOD) begin
            if (r_op == sacl_pkg::OP_LOOK) begin
                r_hit <= look_hit;
            end else if (r_op != sacl_pkg::OP_SWEEP && pf_done) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
        if (r_state == sacl_pkg::ST_FIN && (!r_out_valid || i_m_tready)) begin
            r_out <= {r_cnt, r_hit};
        end
    end

endmodule

[rtl/sacl_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_checker
// Port-level checks for the cache with lookahead prefetch.
// ----------------------------------------------------------------------------
module sacl_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_s_tvalid,
    input logic o_s_tready,
    input logic o_m_tvalid,
    input logic i_m_tready,
    input logic [7:0] o_m_tdata
);

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[2:1] != 2'd3)
        else $error("prefetch count out of range");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && !o_s_tready)
        else $error("activity right after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken while an access is in progress");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result word changed");

endmodule

bind set_assoc_cache_lookahead_prefetch sacl_checker u_sacl_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_s_tvalid(i_s_tvalid),
    .o_s_tready(o_s_tready),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata(o_m_tdata)
);

[tb/tb_set_assoc_cache_lookahead_prefetch.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_lookahead_prefetch
// Self-checking bench for the set-associative cache with lookahead prefetch.
// A driver streams access words in random bursts, and an access-level
// software copy of the tag store predicts hit and prefetch count for each.
// A monitor compares each result word with the oldest prediction. The run
// steps through several register settings; the first is written during the
// clearing pass after reset, each later one once the block is idle again.
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_lookahead_prefetch;

    localparam int OFF_W = 6;
    localparam int SET_W = 6;
    localparam int NWAYS = 4;
    localparam int ADDR_W = 48;
    localparam int NSETS = 1 << SET_W;
    localparam int TAG_W = ADDR_W - OFF_W - SET_W;
    localparam int DATA_W = ((3 * ADDR_W + 7) / 8) * 8;
    localparam int DRAIN_CYCLES = 400;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic              is_load;
        logic              look;
        logic [ADDR_W-1:0] next1;
        logic [ADDR_W-1:0] next2;
    } access_t;

    typedef struct {
        logic       hit;
        logic [1:0] pf_count;
    } outcome_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [sacl_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [sacl_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_s_tvalid = 1'b0;
    logic o_s_tready;
    logic [DATA_W-1:0] i_s_tdata = '0;
    logic [1:0] i_s_tuser = '0;
    logic o_m_tvalid;
    logic i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;

    set_assoc_cache_lookahead_prefetch #(
        .OFFSET_BITS(OFF_W), .SET_BITS(SET_W), .WAYS(NWAYS), .ADDRESS_BITS(ADDR_W)
    ) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Shadow copy of the tag store and its registers.
    logic [TAG_W-1:0] tags [NSETS][NWAYS];
    logic             vbits [NSETS][NWAYS];
    logic [15:0]      ages [NSETS][NWAYS];
    logic [15:0]      lfsr;
    logic             cfg_wt;
    logic             cfg_lru;
    logic [15:0]      cfg_expiry;

    access_t  pending_q [$];
    outcome_t outcome_q [$];
    int       errors = 0;
    longint   cycles = 0;
    int       results_seen = 0;
    logic [ADDR_W-1:0] tag_pool [6];

    function automatic logic [15:0] sat_inc(logic [15:0] a);
        return (a == sacl_pkg::AGE_MAX) ? a : a + 16'd1;
    endfunction

    function automatic int line_set(logic [ADDR_W-1:0] a);
        return int'(a[OFF_W +: SET_W]);
    endfunction

    function automatic logic [TAG_W-1:0] line_tag(logic [ADDR_W-1:0] a);
        return a[ADDR_W-1 -: TAG_W];
    endfunction

    function automatic int try_prefetch(logic [ADDR_W-1:0] a);
        int s;
        int pos;
        logic found;
        logic [15:0] mx;
        logic [TAG_W-1:0] t;
        s = line_set(a);
        t = line_tag(a);
        found = 1'b0;
        pos = 0;
        mx = '0;
        for (int w = 0; w < NWAYS; w++) begin
            if (!vbits[s][w] && !found) begin
                found = 1'b1;
                pos = w;
            end
            if (ages[s][w] > mx) mx = ages[s][w];
        end
        if (!found) return 0;
        for (int w = 0; w < NWAYS; w++)
            if (vbits[s][w] && tags[s][w] == t) return 0;
        vbits[s][pos] = 1'b1;
        tags[s][pos] = t;
        ages[s][pos] = sat_inc(mx);
        return 1;
    endfunction

    function automatic outcome_t predict_access(access_t it);
        outcome_t r;
        int s;
        int victim;
        int cnt;
        logic hit;
        logic [15:0] a;
        logic [TAG_W-1:0] t;
        s = line_set(it.addr);
        t = line_tag(it.addr);
        cnt = 0;
        hit = 1'b0;
        victim = 0;
        if (cfg_wt || it.is_load) begin
            for (int i = 0; i < NSETS; i++)
                for (int w = 0; w < NWAYS; w++) begin
                    a = sat_inc(ages[i][w]);
                    if (a >= cfg_expiry) begin
                        vbits[i][w] = 1'b0;
                        tags[i][w] = '0;
                        a = '0;
                    end
                    ages[i][w] = a;
                end
        end else begin
            for (int w = 0; w < NWAYS; w++) ages[s][w] = sat_inc(ages[s][w]);
        end
        for (int w = 0; w < NWAYS; w++) begin
            if (vbits[s][w] && tags[s][w] == t) begin
                hit = 1'b1;
                ages[s][w] = '0;
            end else if (ages[s][w] > ages[s][victim]) begin
                victim = w;
            end
        end
        if (cfg_wt || it.is_load) begin
            if (!cfg_lru) begin
                lfsr = lfsr[0] ? ((lfsr >> 1) ^ sacl_pkg::LFSR_MASK) : (lfsr >> 1);
                victim = int'(lfsr) % NWAYS;
            end
            if (!hit) begin
                tags[s][victim] = t;
                ages[s][victim] = '0;
                vbits[s][victim] = 1'b1;
            end
            if (it.look) begin
                cnt += try_prefetch(it.next1);
                cnt += try_prefetch(it.next2);
            end
        end
        r.hit = hit;
        r.pf_count = cnt[1:0];
        return r;
    endfunction

    // Driver: bursts of words separated by random gaps.
    access_t cur;
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) outcome_q.push_back(predict_access(cur));
            if (i_s_tvalid && !o_s_tready) begin
                // hold the word
            end else if (gap_left > 0) begin
                gap_left--;
                i_s_tvalid <= 1'b0;
            end else if (pending_q.size() > 0) begin
                cur = pending_q.pop_front();
                i_s_tdata <= {cur.next2, cur.next1, cur.addr};
                i_s_tuser <= {cur.look, cur.is_load};
                i_s_tvalid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
                end
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor with its own stall pattern and one long hold-off.
    int hold_left = 0;
    logic long_hold_done = 1'b0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("set_assoc_cache_lookahead_prefetch test failed");
            $finish;
        end
        if (o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (outcome_q.size() == 0) begin
                $error("unexpected result word: %h", o_m_tdata);
                errors++;
            end else begin
                outcome_t e;
                e = outcome_q.pop_front();
                if (o_m_tdata[0] !== e.hit) begin
                    $error("hit: expected %0d, actual %0d", e.hit, o_m_tdata[0]);
                    errors++;
                end
                if (o_m_tdata[2:1] !== e.pf_count) begin
                    $error("prefetch_count: expected %0d, actual %0d",
                           e.pf_count, o_m_tdata[2:1]);
                    errors++;
                end
                if (o_m_tdata[7:3] !== 5'd0) begin
                    $error("zero fill: expected 0, actual %0d", o_m_tdata[7:3]);
                    errors++;
                end
            end
        end
        if (!long_hold_done && results_seen == 60) begin
            long_hold_done <= 1'b1;
            hold_left = 3000;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else if (cycles[10]) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic write_reg(logic [sacl_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            sacl_pkg::REG_WRITE_THROUGH: cfg_wt = val[0];
            sacl_pkg::REG_USE_LRU:       cfg_lru = val[0];
            sacl_pkg::REG_EXPIRY_LIMIT:  cfg_expiry = val;
            default: ;
        endcase
    endtask

    task automatic configure(logic wt, logic lru, logic [15:0] expiry);
        write_reg(sacl_pkg::REG_WRITE_THROUGH, {15'd0, wt});
        write_reg(sacl_pkg::REG_USE_LRU, {15'd0, lru});
        write_reg(sacl_pkg::REG_EXPIRY_LIMIT, expiry);
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (pending_q.size() != 0 || outcome_q.size() != 0 || i_s_tvalid);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_access(logic [ADDR_W-1:0] a, logic ld, logic lk,
                               logic [ADDR_W-1:0] n1, logic [ADDR_W-1:0] n2);
        access_t it;
        it.addr = a;
        it.is_load = ld;
        it.look = lk;
        it.next1 = n1;
        it.next2 = n2;
        pending_q.push_back(it);
    endtask

    function automatic logic [ADDR_W-1:0] pick_addr();
        logic [ADDR_W-1:0] a;
        if ($urandom_range(0, 7) == 0) begin
            a = ADDR_W'({$urandom, $urandom});
        end else begin
            a = tag_pool[$urandom_range(0, 5)];
            a[OFF_W +: SET_W] = SET_W'($urandom_range(0, 5));
            a[OFF_W-1:0] = OFF_W'($urandom);
        end
        return a;
    endfunction

    task automatic random_phase(int n);
        logic [ADDR_W-1:0] a;
        for (int k = 0; k < n; k++) begin
            a = pick_addr();
            push_access(a, $urandom_range(0, 9) < 7, $urandom_range(0, 9) < 7,
                        ($urandom_range(0, 1) != 0) ? a + 48'd64 : pick_addr(),
                        ($urandom_range(0, 1) != 0) ? a + 48'd128 : pick_addr());
        end
    endtask

    initial begin
        logic [ADDR_W-1:0] ones;
        ones = '1;
        foreach (tag_pool[i]) tag_pool[i] = ADDR_W'({$urandom, $urandom});
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (int i = 0; i < NSETS; i++)
            for (int w = 0; w < NWAYS; w++) begin
                tags[i][w] = '0;
                vbits[i][w] = 1'b0;
                ages[i][w] = '0;
            end
        lfsr = sacl_pkg::LFSR_SEED;
        cfg_wt = 1'b0;
        cfg_lru = 1'b1;
        cfg_expiry = sacl_pkg::EXPIRY_RESET;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        configure(1'b0, 1'b1, 16'd1024);
        push_access('0, 1'b1, 1'b1, 48'h40, 48'h40);
        push_access('0, 1'b1, 1'b0, '0, '0);
        push_access('0, 1'b0, 1'b1, 48'h80, 48'hC0);
        push_access(48'h1000_0000_0040, 1'b0, 1'b0, '0, '0);
        push_access(ones, 1'b1, 1'b1, ones, 48'hFFFF_FFFF_FFC0);
        push_access(ones, 1'b1, 1'b0, '0, '0);
        for (int k = 0; k < 4; k++)
            push_access({36'(k + 1), 6'd5, 6'd0}, 1'b1, 1'b0, '0, '0);
        push_access({36'd9, 6'd5, 6'd0}, 1'b1, 1'b1,
                    {36'd10, 6'd5, 6'd0}, {36'd11, 6'd6, 6'd0});
        push_access({36'd2, 6'd5, 6'd7}, 1'b0, 1'b0, '0, '0);
        push_access(48'hA5A5_5A5A_A5A5, 1'b0, 1'b1, 48'h5A5A_A5A5_5A5A, ones);
        drain();

        configure(1'b1, 1'b1, 16'd65535);
        random_phase(200);
        drain();
        configure(1'b0, 1'b0, 16'd300);
        random_phase(200);
        drain();
        configure(1'b1, 1'b0, 16'd1);
        random_phase(190);
        drain();
        configure(1'b1, 1'b1, 16'd0);
        random_phase(190);
        drain();
        configure(1'b0, 1'b1, 16'd40);
        random_phase(200);
        drain();

        if (errors == 0) begin
            $display("set_assoc_cache_lookahead_prefetch test passed");
        end else begin
            $display("set_assoc_cache_lookahead_prefetch test failed");
        end
        $finish;
    end

endmodule
